/* rtl/core/mnvst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note voice slot tracker - shared definitions
// Widths, message codes, fixed-point constants, the semitone table and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package mnvst_pkg;

  localparam int VOICE_SLOTS = 16;
  localparam int SLOT_W      = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;

  localparam int ACT_W   = 2;
  localparam int NOTE_W  = 7;
  localparam int SEQ_W   = 64;
  localparam int GAIN_W  = 17;
  localparam int PITCH_W = 22;

  localparam logic [ACT_W-1:0]  ACT_NOTE_ON       = 2'd0;
  localparam logic [ACT_W-1:0]  ACT_NOTE_OFF      = 2'd1;
  localparam logic [ACT_W-1:0]  ACT_CONTROL_CHANGE = 2'd2;
  localparam logic [NOTE_W-1:0] CC_MODWHEEL       = 7'd1;

  // Gain: round(v*v*65536 / 127^2) via reciprocal multiply.
  localparam int VEL_FULL_SQ = 16129;
  localparam int GAIN_NUM_W  = 30;
  localparam int GAIN_SHIFT  = 44;
  localparam int GAIN_RCP_W  = 31;
  localparam int GAIN_PROD_W = GAIN_NUM_W + GAIN_RCP_W;
  localparam logic [GAIN_NUM_W-1:0] GAIN_BIAS = GAIN_NUM_W'(VEL_FULL_SQ / 2);
  localparam logic [GAIN_RCP_W-1:0] GAIN_RECIP =
    GAIN_RCP_W'(((64'd1 << GAIN_SHIFT) / 64'(VEL_FULL_SQ)) + 64'd1);

  // Octave split: note/12 == (note*43) >> 9 for any 7-bit note.
  localparam logic [5:0] OCT_RECIP     = 6'd43;
  localparam int         OCT_SHIFT     = 9;
  localparam logic [6:0] SEMIS_PER_OCT = 7'd12;
  localparam logic [3:0] TOP_OCT_SHIFT = 4'd10;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic math_sq;
    logic math_mul;
    logic commit;
  } mnvst_cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } mnvst_stat_t;

  // round(2^(s/12) * 2^21)
  function automatic logic [PITCH_W-1:0] semitone_q21(input logic [3:0] semi);
    logic [PITCH_W-1:0] val;
    case (semi)
      4'd0:    val = 22'd2097152;
      4'd1:    val = 22'd2221855;
      4'd2:    val = 22'd2353974;
      4'd3:    val = 22'd2493948;
      4'd4:    val = 22'd2642246;
      4'd5:    val = 22'd2799362;
      4'd6:    val = 22'd2965821;
      4'd7:    val = 22'd3142178;
      4'd8:    val = 22'd3329021;
      4'd9:    val = 22'd3526975;
      4'd10:   val = 22'd3736700;
      4'd11:   val = 22'd3958896;
      default: val = 22'd0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/core/midi_note_voice_slot_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note voice slot tracker - top level
// Allocates voice slots for note-on, releases them on note-off and latches
// the modwheel controller; one result per parsed MIDI request.
// ----------------------------------------------------------------------------
// Every request produces exactly one result. Requests are handled one at a
// time: a request occupies the block from acceptance until the next request
// can be taken. The scan walks the slot table one slot per cycle and stops
// at the first matching slot, or after the last of the VOICE_SLOTS (16)
// slots when nothing matches; control change and ignored requests do not
// search the table. The other states are the squaring of the velocity, the
// reciprocal multiply for the gain, and the commit into the output register
// (which waits while that register is still stalled). A new request is
// taken while the previous result waits downstream. The voice stealing
// register is written through the cfg channel, which is always ready; write
// it only while the block is idle.
// ----------------------------------------------------------------------------
module midi_note_voice_slot_tracker
  import mnvst_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ACT_W-1:0]   action,
  input  logic [NOTE_W-1:0]  key_or_controller,
  input  logic [NOTE_W-1:0]  velocity_or_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               event_valid,
  output logic               is_note_on,
  output logic [SEQ_W-1:0]   sequence_tag,
  output logic [GAIN_W-1:0]  velocity_gain,
  output logic [PITCH_W-1:0] pitch_ratio,
  output logic [NOTE_W-1:0]  launched_key,
  output logic [NOTE_W-1:0]  modwheel_level,
  // configuration: voice stealing enable
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  mnvst_cmd_t  cmd;
  mnvst_stat_t stat;

  // cfg writes go straight into the register, so never push back
  assign cfg_ready = 1'b1;

  // sequence the request: capture, scan, math, commit
  mnvst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hold the slot table, counters and the output register
  mnvst_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .action            (action),
    .key_or_controller (key_or_controller),
    .velocity_or_value (velocity_or_value),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .event_valid       (event_valid),
    .is_note_on        (is_note_on),
    .sequence_tag      (sequence_tag),
    .velocity_gain     (velocity_gain),
    .pitch_ratio       (pitch_ratio),
    .launched_key      (launched_key),
    .modwheel_level    (modwheel_level)
  );

endmodule

/* rtl/core/mnvst_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note voice slot tracker - controller
// Sequences one request: capture, slot scan, gain math, commit to output.
// ----------------------------------------------------------------------------
module mnvst_ctrl
  import mnvst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  mnvst_stat_t stat,
  output mnvst_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN     = 3'd1;
  localparam logic [2:0] ST_MATH_SQ  = 3'd2;
  localparam logic [2:0] ST_MATH_MUL = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (!stat.needs_scan || stat.scan_hit || stat.scan_last) begin
          state_next = ST_MATH_SQ;
        end
      end
      ST_MATH_SQ: begin
        cmd.math_sq = 1'b1;
        state_next  = ST_MATH_MUL;
      end
      ST_MATH_MUL: begin
        cmd.math_mul = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/mnvst_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note voice slot tracker - datapath
// Slot table, sequence counter, modwheel latch, gain/pitch math and the
// output register.
// ----------------------------------------------------------------------------
module mnvst_datapath
  import mnvst_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  mnvst_cmd_t         cmd,
  output mnvst_stat_t        stat,
  input  logic [ACT_W-1:0]   action,
  input  logic [NOTE_W-1:0]  key_or_controller,
  input  logic [NOTE_W-1:0]  velocity_or_value,
  input  logic               cfg_valid,
  input  logic               cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               event_valid,
  output logic               is_note_on,
  output logic [SEQ_W-1:0]   sequence_tag,
  output logic [GAIN_W-1:0]  velocity_gain,
  output logic [PITCH_W-1:0] pitch_ratio,
  output logic [NOTE_W-1:0]  launched_key,
  output logic [NOTE_W-1:0]  modwheel_level
);

  // captured request
  logic [ACT_W-1:0]  req_action;
  logic [NOTE_W-1:0] req_key;
  logic [NOTE_W-1:0] req_vel;

  // slot table
  logic [VOICE_SLOTS-1:0] slot_active;
  logic [NOTE_W-1:0]      slot_note     [VOICE_SLOTS];
  logic [SEQ_W-1:0]       slot_sequence [VOICE_SLOTS];

  logic [SLOT_W-1:0] scan_idx;
  logic [SLOT_W-1:0] hit_idx;
  logic              hit;
  logic [SEQ_W-1:0]  hit_seq;

  logic [SEQ_W-1:0]  seq_counter;
  logic [NOTE_W-1:0] modwheel;
  logic              steal_on;

  logic [2*NOTE_W-1:0] vel_sq;
  logic [PITCH_W-1:0]  pitch_q;
  logic [GAIN_W-1:0]   gain_q;

  logic                   is_launch;
  logic                   is_release;
  logic                   cur_match;
  logic                   launch_fire;
  logic                   release_fire;
  logic                   cc_mod;
  logic [SLOT_W-1:0]      target_idx;
  logic [SEQ_W-1:0]       seq_next;

  logic [12:0]            oct_prod;
  logic [3:0]             oct;
  logic [NOTE_W-1:0]      semi_full;
  logic [3:0]             shamt;
  logic [PITCH_W-1:0]     pitch_base;
  logic [PITCH_W:0]       pitch_sum;
  logic [PITCH_W-1:0]     pitch_calc;
  logic [GAIN_NUM_W-1:0]  gain_num;
  logic [GAIN_PROD_W-1:0] gain_prod;

  assign is_launch  = (req_action == ACT_NOTE_ON) && (req_vel != '0);
  assign is_release = ((req_action == ACT_NOTE_ON) && (req_vel == '0)) ||
                      (req_action == ACT_NOTE_OFF);
  assign cc_mod     = (req_action == ACT_CONTROL_CHANGE) && (req_key == CC_MODWHEEL);

  assign cur_match = is_launch ? !slot_active[scan_idx]
                               : (slot_active[scan_idx] && (slot_note[scan_idx] == req_key));

  assign stat.needs_scan = is_launch || is_release;
  assign stat.scan_hit   = cur_match;
  assign stat.scan_last  = (scan_idx == SLOT_W'(VOICE_SLOTS - 1));
  assign stat.out_free   = !out_valid || !out_stall;

  assign launch_fire  = is_launch && (hit || steal_on);
  assign release_fire = is_release && hit;
  assign target_idx   = hit ? hit_idx : '0;
  assign seq_next     = seq_counter + SEQ_W'(1);

  // pitch: table[note mod 12] >> (10 - note/12), round half up
  always_comb begin
    oct_prod   = 13'(req_key) * 13'(OCT_RECIP);
    oct        = oct_prod[12:OCT_SHIFT];
    semi_full  = req_key - NOTE_W'({3'b000, oct} * SEMIS_PER_OCT);
    shamt      = TOP_OCT_SHIFT - oct;
    pitch_base = semitone_q21(semi_full[3:0]);
    pitch_sum  = '0;
    pitch_calc = pitch_base;
    if (shamt != '0) begin
      pitch_sum  = ({1'b0, pitch_base} + ((PITCH_W+1)'(1) << (shamt - 4'd1))) >> shamt;
      pitch_calc = pitch_sum[PITCH_W-1:0];
    end
  end

  assign gain_num  = {vel_sq, 16'b0} + GAIN_BIAS;
  assign gain_prod = GAIN_PROD_W'(gain_num) * GAIN_PROD_W'(GAIN_RECIP);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
      seq_counter <= '0;
      modwheel    <= '0;
      steal_on    <= 1'b0;
      out_valid   <= 1'b0;
      hit         <= 1'b0;
      scan_idx    <= '0;
    end else begin
      if (cfg_valid) begin
        steal_on <= cfg_data;
      end
      if (cmd.capture) begin
        hit      <= 1'b0;
        scan_idx <= '0;
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + SLOT_W'(1);
        if (stat.needs_scan && cur_match) begin
          hit <= 1'b1;
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (launch_fire) begin
          seq_counter             <= seq_next;
          slot_active[target_idx] <= 1'b1;
        end
        if (release_fire) begin
          slot_active[hit_idx] <= 1'b0;
        end
        if (cc_mod) begin
          modwheel <= req_vel;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_action <= action;
      req_key    <= key_or_controller;
      req_vel    <= velocity_or_value;
    end
    if (cmd.scan_step && stat.needs_scan && cur_match) begin
      hit_idx <= scan_idx;
      hit_seq <= slot_sequence[scan_idx];
    end
    if (cmd.math_sq) begin
      vel_sq  <= (2*NOTE_W)'(req_vel) * (2*NOTE_W)'(req_vel);
      pitch_q <= pitch_calc;
    end
    if (cmd.math_mul) begin
      gain_q <= gain_prod[GAIN_SHIFT +: GAIN_W];
    end
    if (cmd.commit) begin
      if (launch_fire) begin
        slot_note[target_idx]     <= req_key;
        slot_sequence[target_idx] <= seq_next;
      end
      if (release_fire) begin
        slot_note[hit_idx]     <= '0;
        slot_sequence[hit_idx] <= '0;
      end
      event_valid    <= launch_fire || release_fire;
      is_note_on     <= launch_fire;
      sequence_tag   <= launch_fire ? seq_next : (release_fire ? hit_seq : '0);
      velocity_gain  <= launch_fire ? gain_q : '0;
      pitch_ratio    <= launch_fire ? pitch_q : '0;
      launched_key   <= launch_fire ? req_key : '0;
      modwheel_level <= cc_mod ? req_vel : modwheel;
    end
  end

endmodule

/* rtl/core/mnvst_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note voice slot tracker - port checker
// Checks result field consistency and request pacing at the top level ports.
// ----------------------------------------------------------------------------
module mnvst_checker
  import mnvst_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               event_valid,
  input logic               is_note_on,
  input logic [SEQ_W-1:0]   sequence_tag,
  input logic [GAIN_W-1:0]  velocity_gain,
  input logic [PITCH_W-1:0] pitch_ratio,
  input logic [NOTE_W-1:0]  launched_key
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sequence_tag) && $stable(is_note_on))
    else $error("stalled result changed");

  // no event: all note fields clear
  a_no_event_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_valid |-> !is_note_on && sequence_tag == '0 &&
      velocity_gain == '0 && pitch_ratio == '0 && launched_key == '0)
    else $error("empty result carries note data");

  // release: only the sequence tag is set
  a_release_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_valid && !is_note_on |->
      velocity_gain == '0 && pitch_ratio == '0 && launched_key == '0)
    else $error("release carries launch data");

  // launch: an event with nonzero gain, pitch and sequence
  a_launch_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_note_on |-> event_valid && velocity_gain != '0 &&
      pitch_ratio != '0 && sequence_tag != '0)
    else $error("launch with empty fields");

  // one request at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken back to back");

endmodule

bind midi_note_voice_slot_tracker mnvst_checker u_mnvst_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .event_valid   (event_valid),
  .is_note_on    (is_note_on),
  .sequence_tag  (sequence_tag),
  .velocity_gain (velocity_gain),
  .pitch_ratio   (pitch_ratio),
  .launched_key  (launched_key)
);

/* bench/midi_note_voice_slot_tracker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note voice slot tracker - self-checking testbench
// Drives parsed MIDI requests with random gaps and output stalls and predicts
// every result from a behavioral copy of the voice slot table. It walks a
// directed table, fills the slot table with stealing off, steals a slot with
// stealing on, then runs random phases under both stealing settings. One
// phase holds the result channel off for a long stretch so the input backs up.
// ----------------------------------------------------------------------------
module midi_note_voice_slot_tracker_tb;
  import mnvst_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = VOICE_SLOTS + 8;   // longest scan plus margin
  localparam int HOLD_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int IDLE_PERCENT  = 11;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 190;
  localparam int DIRECTED_ROWS = 19;
  localparam int KEY_POOL      = 20;

  // Action 3 carries any other message; the block ignores it.
  localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd3;

  // 2^(s/12) in Q21, one entry per semitone of an octave
  localparam logic [PITCH_W-1:0] OCTAVE_STEPS [12] = '{
    22'd2097152, 22'd2221855, 22'd2353974, 22'd2493948,
    22'd2642246, 22'd2799362, 22'd2965821, 22'd3142178,
    22'd3329021, 22'd3526975, 22'd3736700, 22'd3958896
  };

  typedef struct packed {
    logic               has_event;
    logic               launch;
    logic [SEQ_W-1:0]   tag;
    logic [GAIN_W-1:0]  gain;
    logic [PITCH_W-1:0] pitch;
    logic [NOTE_W-1:0]  note;
    logic [NOTE_W-1:0]  modwheel;
  } note_event_t;

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [NOTE_W-1:0] key;
    logic [NOTE_W-1:0] value;
    bit                typed;
    note_event_t       want;
  } stim_row_t;

  // DUT signals
  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [ACT_W-1:0]   action;
  logic [NOTE_W-1:0]  key_or_controller;
  logic [NOTE_W-1:0]  velocity_or_value;
  logic               out_valid;
  logic               out_stall;
  logic               event_valid;
  logic               is_note_on;
  logic [SEQ_W-1:0]   sequence_tag;
  logic [GAIN_W-1:0]  velocity_gain;
  logic [PITCH_W-1:0] pitch_ratio;
  logic [NOTE_W-1:0]  launched_key;
  logic [NOTE_W-1:0]  modwheel_level;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_data;

  // Predicted slot table and its companions
  logic              voice_busy [VOICE_SLOTS];
  logic [NOTE_W-1:0] voice_key  [VOICE_SLOTS];
  logic [SEQ_W-1:0]  voice_tag  [VOICE_SLOTS];
  logic [SEQ_W-1:0]  seq_model;
  logic [NOTE_W-1:0] mod_latch;
  logic              steal_enable;

  note_event_t pending_events [$];
  stim_row_t   directed_rows [DIRECTED_ROWS];

  int  mismatch_count = 0;
  int  checked_count  = 0;
  int  request_count  = 0;
  int  launch_count   = 0;
  int  release_count  = 0;
  int  drop_count     = 0;
  int  steal_count    = 0;
  int  cycle_count    = 0;
  bit  steady         = 1'b0;  // suppress idling on both sides
  bit  hold_request   = 1'b0;  // ask the receiver for one long hold-off
  bit  hold_served    = 1'b0;

  midi_note_voice_slot_tracker uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .action           (action),
    .key_or_controller(key_or_controller),
    .velocity_or_value(velocity_or_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .event_valid      (event_valid),
    .is_note_on       (is_note_on),
    .sequence_tag     (sequence_tag),
    .velocity_gain    (velocity_gain),
    .pitch_ratio      (pitch_ratio),
    .launched_key     (launched_key),
    .modwheel_level   (modwheel_level),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Gain is round(v*v*65536 / 127^2), half up.
  function automatic logic [GAIN_W-1:0] expected_gain(input logic [NOTE_W-1:0] vel);
    longint unsigned sq;
    sq = 64'(vel) * 64'(vel) * 64'd65536;
    return GAIN_W'((sq + 64'(VEL_FULL_SQ / 2)) / 64'(VEL_FULL_SQ));
  endfunction

  // Pitch is the semitone step shifted down by the octaves below the top one,
  // rounded half up; the top octave takes the table value as it is.
  function automatic logic [PITCH_W-1:0] expected_pitch(input logic [NOTE_W-1:0] key);
    int            octave;
    int            semi;
    int            shift;
    logic [PITCH_W:0] base;
    octave = key / 12;
    semi   = key % 12;
    shift  = 10 - octave;
    base   = {1'b0, OCTAVE_STEPS[semi]};
    if (shift == 0) return base[PITCH_W-1:0];
    return PITCH_W'((base + ((PITCH_W+1)'(1) << (shift - 1))) >> shift);
  endfunction

  // Advance the predicted slot table by one request and return its result.
  function automatic note_event_t predict_event(input logic [ACT_W-1:0] act,
                                                input logic [NOTE_W-1:0] key,
                                                input logic [NOTE_W-1:0] val);
    note_event_t r;
    int          slot;
    r    = '0;
    slot = -1;
    if (act == ACT_NOTE_ON && val != '0) begin
      // lowest free slot, else slot 0 if stealing, else drop
      for (int i = 0; i < VOICE_SLOTS; i++) begin
        if (slot < 0 && !voice_busy[i]) slot = i;
      end
      if (slot < 0 && steal_enable) begin
        slot = 0;
        steal_count++;
      end
      if (slot < 0) begin
        drop_count++;
      end else begin
        seq_model        = seq_model + SEQ_W'(1);
        voice_busy[slot] = 1'b1;
        voice_key[slot]  = key;
        voice_tag[slot]  = seq_model;
        r.has_event = 1'b1;
        r.launch    = 1'b1;
        r.tag       = seq_model;
        r.gain      = expected_gain(val);
        r.pitch     = expected_pitch(key);
        r.note      = key;
        launch_count++;
      end
    end else if (act == ACT_NOTE_ON || act == ACT_NOTE_OFF) begin
      // release the lowest active slot holding this note
      for (int i = 0; i < VOICE_SLOTS; i++) begin
        if (slot < 0 && voice_busy[i] && voice_key[i] == key) slot = i;
      end
      if (slot >= 0) begin
        r.has_event      = 1'b1;
        r.tag            = voice_tag[slot];
        voice_busy[slot] = 1'b0;
        voice_key[slot]  = '0;
        voice_tag[slot]  = '0;
        release_count++;
      end
    end else if (act == ACT_CONTROL_CHANGE && key == CC_MODWHEEL) begin
      mod_latch = val;
    end
    r.modwheel = mod_latch;
    return r;
  endfunction

  // Typed expectations for the directed table
  function automatic note_event_t none_event(input logic [NOTE_W-1:0] mod);
    note_event_t r;
    r          = '0;
    r.modwheel = mod;
    return r;
  endfunction

  function automatic note_event_t release_event(input logic [SEQ_W-1:0] tag,
                                                input logic [NOTE_W-1:0] mod);
    note_event_t r;
    r           = none_event(mod);
    r.has_event = 1'b1;
    r.tag       = tag;
    return r;
  endfunction

  function automatic note_event_t launch_event(input logic [SEQ_W-1:0] tag,
                                               input logic [GAIN_W-1:0] gain,
                                               input logic [PITCH_W-1:0] pitch,
                                               input logic [NOTE_W-1:0] note,
                                               input logic [NOTE_W-1:0] mod);
    note_event_t r;
    r        = release_event(tag, mod);
    r.launch = 1'b1;
    r.gain   = gain;
    r.pitch  = pitch;
    r.note   = note;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver tasks
  // --------------------------------------------------------------------------

  // Offer one request, hold it until accepted, then queue its expected
  // result. The typed expectation wins over the prediction where given; the
  // prediction still runs so the slot table stays in step.
  task automatic send_request(input logic [ACT_W-1:0] act,
                              input logic [NOTE_W-1:0] key,
                              input logic [NOTE_W-1:0] val,
                              input bit typed,
                              input note_event_t want);
    note_event_t predicted;
    in_valid          <= 1'b1;
    action            <= act;
    key_or_controller <= key;
    velocity_or_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_event(act, key, val);
    pending_events.push_back(typed ? want : predicted);
    request_count++;
    // random sender gap; skipped during the steady stretch
    if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every result is out and the scan has settled.
  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the stealing enable while the block is idle.
  task automatic set_stealing(input logic enable);
    drain_requests();
    cfg_valid <= 1'b1;
    cfg_data  <= enable;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    steal_enable  = enable;
  endtask

  // Mostly well-formed note traffic over a small key pool so that note-offs
  // find their slots and the table fills; the rest is full-range noise and
  // requests the block ignores. Only requests that matter count.
  task automatic run_random_phase(input int count);
    int                done;
    int                pick;
    logic [ACT_W-1:0]  act;
    logic [NOTE_W-1:0] key;
    logic [NOTE_W-1:0] val;
    logic [NOTE_W-1:0] pool_base;
    bit                ignored;
    done      = 0;
    pool_base = NOTE_W'($urandom_range(0, 127 - KEY_POOL));
    while (done < count) begin
      pick = $urandom_range(0, 99);
      key  = pool_base + NOTE_W'($urandom_range(0, KEY_POOL - 1));
      val  = NOTE_W'($urandom_range(1, 127));
      if (pick < 48) begin
        act = ACT_NOTE_ON;
      end else if (pick < 80) begin
        act = ACT_NOTE_OFF;
        val = NOTE_W'($urandom_range(0, 127));
      end else if (pick < 85) begin
        act = ACT_NOTE_ON;   // zero velocity acts as a release
        val = '0;
      end else if (pick < 91) begin
        act = ACT_CONTROL_CHANGE;
        key = CC_MODWHEEL;
        val = NOTE_W'($urandom_range(0, 127));
      end else begin
        act = ACT_W'($urandom_range(0, 3));
        key = NOTE_W'($urandom_range(0, 127));
        val = NOTE_W'($urandom_range(0, 127));
      end
      ignored = (act == ACT_IGNORED) ||
                (act == ACT_CONTROL_CHANGE && key != CC_MODWHEEL);
      send_request(act, key, val, 1'b0, '0);
      if (!ignored) done++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        // hold the result channel while the sender keeps offering
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    note_event_t got;
    note_event_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{event_valid, is_note_on, sequence_tag, velocity_gain,
              pitch_ratio, launched_key, modwheel_level};
      if (pending_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] result with no pending request: ev=%0b on=%0b tag=%0d",
                   $realtime, got.has_event, got.launch, got.tag);
      end else begin
        want = pending_events.pop_front();
        checked_count++;
        if (got.has_event !== want.has_event || got.launch !== want.launch ||
            got.tag !== want.tag || got.gain !== want.gain ||
            got.pitch !== want.pitch || got.note !== want.note ||
            got.modwheel !== want.modwheel) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch on result %0d", $realtime, checked_count);
            $display("  expected ev=%0b on=%0b tag=%0d gain=%0d pitch=%0d note=%0d mod=%0d",
                     want.has_event, want.launch, want.tag, want.gain,
                     want.pitch, want.note, want.modwheel);
            $display("  actual   ev=%0b on=%0b tag=%0d gain=%0d pitch=%0d note=%0d mod=%0d",
                     got.has_event, got.launch, got.tag, got.gain,
                     got.pitch, got.note, got.modwheel);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if it takes far longer than the slowest correct one
  // --------------------------------------------------------------------------
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [NOTE_W-1:0] held_note;

    // known values on every input from time zero
    rst               <= 1'b1;
    in_valid          <= 1'b0;
    action            <= ACT_NOTE_ON;
    key_or_controller <= '0;
    velocity_or_value <= '0;
    cfg_valid         <= 1'b0;
    cfg_data          <= 1'b0;

    // predictor starts in the reset state
    for (int i = 0; i < VOICE_SLOTS; i++) begin
      voice_busy[i] = 1'b0;
      voice_key[i]  = '0;
      voice_tag[i]  = '0;
    end
    seq_model    = '0;
    mod_latch    = '0;
    steal_enable = 1'b0;

    // Directed table. Typed rows: reset state, extremes of key and velocity,
    // ignored controllers, release by zero velocity, note-off with no match.
    directed_rows[0]  = '{ACT_CONTROL_CHANGE, CC_MODWHEEL, 7'd127, 1'b1,
                          none_event(7'd127)};
    directed_rows[1]  = '{ACT_CONTROL_CHANGE, 7'd7, 7'd55, 1'b1, none_event(7'd127)};
    directed_rows[2]  = '{ACT_IGNORED, 7'd127, 7'd127, 1'b1, none_event(7'd127)};
    directed_rows[3]  = '{ACT_CONTROL_CHANGE, CC_MODWHEEL, 7'd0, 1'b1, none_event(7'd0)};
    directed_rows[4]  = '{ACT_NOTE_OFF, 7'd60, 7'd64, 1'b1, none_event(7'd0)};
    directed_rows[5]  = '{ACT_NOTE_ON, 7'd60, 7'd127, 1'b1,
                          launch_event(64'd1, 17'd65536, 22'd65536, 7'd60, 7'd0)};
    directed_rows[6]  = '{ACT_NOTE_ON, 7'd0, 7'd1, 1'b1,
                          launch_event(64'd2, 17'd4, 22'd2048, 7'd0, 7'd0)};
    directed_rows[7]  = '{ACT_NOTE_ON, 7'd127, 7'd64, 1'b0, '0};
    directed_rows[8]  = '{ACT_NOTE_ON, 7'd60, 7'd0, 1'b1, release_event(64'd1, 7'd0)};
    directed_rows[9]  = '{ACT_NOTE_OFF, 7'd0, 7'd127, 1'b1, release_event(64'd2, 7'd0)};
    directed_rows[10] = '{ACT_NOTE_OFF, 7'd127, 7'd0, 1'b1, release_event(64'd3, 7'd0)};
    // same note twice: the lower slot goes first
    directed_rows[11] = '{ACT_NOTE_ON, 7'd64, 7'd100, 1'b0, '0};
    directed_rows[12] = '{ACT_NOTE_ON, 7'd64, 7'd100, 1'b0, '0};
    directed_rows[13] = '{ACT_NOTE_OFF, 7'd64, 7'd9, 1'b0, '0};
    directed_rows[14] = '{ACT_NOTE_OFF, 7'd64, 7'd9, 1'b0, '0};
    directed_rows[15] = '{ACT_NOTE_OFF, 7'd64, 7'd9, 1'b1, none_event(7'd0)};
    // alternating bit patterns
    directed_rows[16] = '{ACT_CONTROL_CHANGE, CC_MODWHEEL, 7'd85, 1'b0, '0};
    directed_rows[17] = '{ACT_NOTE_ON, 7'd42, 7'd42, 1'b0, '0};
    directed_rows[18] = '{ACT_NOTE_OFF, 7'd42, 7'd85, 1'b0, '0};

    // single reset pulse, synchronous
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_stealing(1'b0);
    foreach (directed_rows[r]) begin
      send_request(directed_rows[r].act, directed_rows[r].key, directed_rows[r].value,
                   directed_rows[r].typed, directed_rows[r].want);
    end

    // Fill every slot with distinct notes; the extra note-on is dropped
    // while stealing is off.
    for (int i = 0; i <= VOICE_SLOTS; i++) begin
      send_request(ACT_NOTE_ON, NOTE_W'(20 + i * 5), NOTE_W'($urandom_range(1, 127)),
                   1'b0, '0);
    end

    // With stealing on, a note-on takes slot 0; its old note is then gone.
    set_stealing(1'b1);
    send_request(ACT_NOTE_ON, 7'd99, 7'd77, 1'b0, '0);
    send_request(ACT_NOTE_OFF, 7'd20, 7'd0, 1'b0, '0);

    // release whatever is left
    for (int i = 0; i < VOICE_SLOTS; i++) begin
      if (voice_busy[i]) begin
        held_note = voice_key[i];
        send_request(ACT_NOTE_OFF, held_note, NOTE_W'($urandom_range(0, 127)), 1'b0, '0);
      end
    end

    // random phases, alternating the stealing setting
    run_random_phase(PHASE_ITEMS);

    set_stealing(1'b0);
    hold_request = 1'b1;   // back up the input behind a stalled output
    run_random_phase(PHASE_ITEMS);

    set_stealing(1'b1);
    steady = 1'b1;         // a stretch with no idling on either side
    run_random_phase(PHASE_ITEMS / 2);
    steady = 1'b0;
    run_random_phase(PHASE_ITEMS / 2);

    set_stealing(1'b0);
    run_random_phase(PHASE_ITEMS);

    drain_requests();

    $display("Checked %0d results from %0d requests in %0d cycles", checked_count,
             request_count, cycle_count);
    $display("Launches %0d, releases %0d, dropped note-ons %0d, steals %0d",
             launch_count, release_count, drop_count, steal_count);
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
